// ===== hw/rtl/mm4_pkg.sv =====
// shared types and constants for the 4x4 fixed-point matrix multiplier
// no dependencies; used by mm4_ctrl, mm4_dp and matrix_multiply_4x4_top
`timescale 1ns / 1ps
`default_nettype none

package mm4_pkg;

    // result entry width: signed Q10.24, wraps beyond that
    localparam int PROD_W      = 34;
    // row * dim + column, kept to four bits
    localparam int POS_W       = 4;
    // product + position, padded to whole bytes
    localparam int OUT_TDATA_W = ((PROD_W + POS_W + 7) / 8) * 8;

    // per-cycle command from the sequencer into the multiply-accumulate path
    typedef struct packed {
        logic             rd_en;
        logic             first_term;
        logic             last_term;
        logic [POS_W-1:0] position;
        logic             last_result;
    } t_mac_cmd;

endpackage

`default_nettype wire

// ===== hw/rtl/mm4_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mm4_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/mm4_ctrl.sv =====
// sequencer: counts the load beats, then walks row, column and term indexes
// depends on mm4_pkg
`timescale 1ns / 1ps
`default_nettype none

module mm4_ctrl #(
    parameter int MATRIX_DIM = 4
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_in_valid,
    output logic                                           o_in_ready,
    input  wire logic                                      i_advance,
    output logic                                           o_wr_en,
    output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]       o_wr_addr,
    output mm4_pkg::t_mac_cmd                              o_cmd,
    output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]       o_rd_addr_a,
    output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]       o_rd_addr_b
);

    localparam int CELLS  = MATRIX_DIM * MATRIX_DIM;
    localparam int CELL_W = $clog2(CELLS);
    localparam int DIM_W  = $clog2(MATRIX_DIM);

    typedef enum logic [1:0] {
        S_LOAD = 2'b01,
        S_MAC  = 2'b10
    } t_state;

    t_state            r_state, n_state;
    logic [CELL_W-1:0] r_load_cnt, n_load_cnt;
    logic [DIM_W-1:0]  r_row, n_row;
    logic [DIM_W-1:0]  r_col, n_col;
    logic [DIM_W-1:0]  r_k, n_k;

    logic w_load;
    logic w_issue;
    logic w_k_end;
    logic w_col_end;
    logic w_row_end;

    assign w_load    = (r_state == S_LOAD) && i_in_valid;
    assign w_issue   = (r_state == S_MAC) && i_advance;
    assign w_k_end   = (r_k == DIM_W'(MATRIX_DIM - 1));
    assign w_col_end = (r_col == DIM_W'(MATRIX_DIM - 1));
    assign w_row_end = (r_row == DIM_W'(MATRIX_DIM - 1));

    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_row      = r_row;
        n_col      = r_col;
        n_k        = r_k;
        case (r_state)
            S_LOAD: begin
                if (w_load) begin
                    if (r_load_cnt == CELL_W'(CELLS - 1)) begin
                        n_load_cnt = '0;
                        n_state    = S_MAC;
                    end else begin
                        n_load_cnt = r_load_cnt + 1'b1;
                    end
                end
            end
            S_MAC: begin
                if (w_issue) begin
                    if (w_k_end) begin
                        n_k = '0;
                        if (w_col_end) begin
                            n_col = '0;
                            if (w_row_end) begin
                                n_row   = '0;
                                n_state = S_LOAD;
                            end else begin
                                n_row = r_row + 1'b1;
                            end
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load_cnt <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_k        <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_row      <= n_row;
            r_col      <= n_col;
            r_k        <= n_k;
        end
    end

    assign o_in_ready = (r_state == S_LOAD);
    assign o_wr_en    = w_load;
    assign o_wr_addr  = r_load_cnt;

    // a is read along the row, b down the column
    assign o_rd_addr_a = CELL_W'(int'(r_row) * MATRIX_DIM + int'(r_k));
    assign o_rd_addr_b = CELL_W'(int'(r_k) * MATRIX_DIM + int'(r_col));

    always_comb begin
        o_cmd.rd_en       = w_issue;
        o_cmd.first_term  = (r_k == '0);
        o_cmd.last_term   = w_k_end;
        o_cmd.position    = mm4_pkg::POS_W'(int'(r_row) * MATRIX_DIM + int'(r_col));
        o_cmd.last_result = w_k_end && w_col_end && w_row_end;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mm4_dp.sv =====
// datapath: element stores, one shared multiplier, accumulator, output register
// depends on mm4_pkg and mm4_ram
`timescale 1ns / 1ps
`default_nettype none

module mm4_dp #(
    parameter int MATRIX_DIM   = 4,
    parameter int ELEMENT_BITS = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_wr_en,
    input  wire logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]  i_wr_addr,
    input  wire logic [ELEMENT_BITS-1:0]                   i_a_element,
    input  wire logic [ELEMENT_BITS-1:0]                   i_b_element,
    input  wire mm4_pkg::t_mac_cmd                         i_cmd,
    input  wire logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]  i_rd_addr_a,
    input  wire logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]  i_rd_addr_b,
    output logic                                           o_advance,
    output logic                                           o_out_valid,
    input  wire logic                                      i_out_ready,
    output logic [mm4_pkg::PROD_W-1:0]                     o_product_element,
    output logic [mm4_pkg::POS_W-1:0]                      o_result_position,
    output logic                                           o_last_result
);

    localparam int CELLS = MATRIX_DIM * MATRIX_DIM;
    localparam int MUL_W = 2 * ELEMENT_BITS;

    logic [ELEMENT_BITS-1:0] w_a_q;
    logic [ELEMENT_BITS-1:0] w_b_q;

    mm4_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (CELLS)
    ) u_a_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_a_element),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_rd_addr_a),
        .o_rd_data (w_a_q)
    );

    mm4_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (CELLS)
    ) u_b_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_b_element),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_rd_addr_b),
        .o_rd_data (w_b_q)
    );

    // stage 1 tags line up with the registered ram data
    logic                        r_s1_valid;
    logic                        r_s1_first;
    logic                        r_s1_last;
    logic [mm4_pkg::POS_W-1:0]   r_s1_pos;
    logic                        r_s1_lastres;

    logic                        r_s2_valid;
    logic                        r_s2_first;
    logic                        r_s2_last;
    logic [mm4_pkg::POS_W-1:0]   r_s2_pos;
    logic                        r_s2_lastres;
    logic signed [MUL_W-1:0]     r_prod;

    logic [mm4_pkg::PROD_W-1:0]  r_acc;
    logic                        r_out_valid;
    logic [mm4_pkg::PROD_W-1:0]  r_out_prod;
    logic [mm4_pkg::POS_W-1:0]   r_out_pos;
    logic                        r_out_last;

    logic                        w_advance;
    logic                        w_finish;
    logic [mm4_pkg::PROD_W-1:0]  w_term;
    logic [mm4_pkg::PROD_W-1:0]  w_sum;

    // hold the whole path while a finished entry cannot enter the output register
    assign w_advance = !(r_s2_valid && r_s2_last && r_out_valid && !i_out_ready);
    assign w_finish  = w_advance && r_s2_valid && r_s2_last;

    assign w_term = mm4_pkg::PROD_W'(r_prod);
    assign w_sum  = (r_s2_first ? '0 : r_acc) + w_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_s1_valid <= i_cmd.rd_en;
                r_s2_valid <= r_s1_valid;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s1_first   <= i_cmd.first_term;
            r_s1_last    <= i_cmd.last_term;
            r_s1_pos     <= i_cmd.position;
            r_s1_lastres <= i_cmd.last_result;

            r_s2_first   <= r_s1_first;
            r_s2_last    <= r_s1_last;
            r_s2_pos     <= r_s1_pos;
            r_s2_lastres <= r_s1_lastres;
            r_prod       <= $signed(w_a_q) * $signed(w_b_q);

            if (r_s2_valid && !r_s2_last) begin
                r_acc <= w_sum;
            end
        end
        if (w_finish) begin
            r_out_prod <= w_sum;
            r_out_pos  <= r_s2_pos;
            r_out_last <= r_s2_lastres;
        end
    end

    assign o_advance         = w_advance;
    assign o_out_valid       = r_out_valid;
    assign o_product_element = r_out_prod;
    assign o_result_position = r_out_pos;
    assign o_last_result     = r_out_last;

endmodule

`default_nettype wire

// ===== hw/rtl/matrix_multiply_4x4_top.sv =====
// top level of the fixed-point matrix multiplier: R = A * B, row-major beats
// loads take one beat per cycle while s_axis_tready is high; after the last load beat the
// results follow in row-major order while the sink keeps up, and s_axis_tready stays low
// until the last term is issued, so throughput is set by the single shared multiplier
// synchronous active-low reset clears the sequencer and valid flags, not the element stores
// depends on mm4_pkg, mm4_ctrl, mm4_dp and mm4_ram
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_4x4_top #(
    parameter int MATRIX_DIM   = 4,
    parameter int ELEMENT_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // a_element, b_element, zero pad
    input  wire logic [((2*ELEMENT_BITS+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // product_element, result_position, zero pad
    output logic [mm4_pkg::OUT_TDATA_W-1:0]            m_axis_tdata,
    output logic                                       m_axis_tlast
);

    localparam int CELL_W = $clog2(MATRIX_DIM * MATRIX_DIM);

    logic                       w_wr_en;
    logic [CELL_W-1:0]          w_wr_addr;
    logic [CELL_W-1:0]          w_rd_addr_a;
    logic [CELL_W-1:0]          w_rd_addr_b;
    mm4_pkg::t_mac_cmd          w_cmd;
    logic                       w_advance;
    logic [mm4_pkg::PROD_W-1:0] w_product;
    logic [mm4_pkg::POS_W-1:0]  w_position;

    mm4_ctrl #(
        .MATRIX_DIM (MATRIX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_advance   (w_advance),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_cmd       (w_cmd),
        .o_rd_addr_a (w_rd_addr_a),
        .o_rd_addr_b (w_rd_addr_b)
    );

    mm4_dp #(
        .MATRIX_DIM   (MATRIX_DIM),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_wr_en           (w_wr_en),
        .i_wr_addr         (w_wr_addr),
        .i_a_element       (s_axis_tdata[ELEMENT_BITS-1:0]),
        .i_b_element       (s_axis_tdata[2*ELEMENT_BITS-1:ELEMENT_BITS]),
        .i_cmd             (w_cmd),
        .i_rd_addr_a       (w_rd_addr_a),
        .i_rd_addr_b       (w_rd_addr_b),
        .o_advance         (w_advance),
        .o_out_valid       (m_axis_tvalid),
        .i_out_ready       (m_axis_tready),
        .o_product_element (w_product),
        .o_result_position (w_position),
        .o_last_result     (m_axis_tlast)
    );

    assign m_axis_tdata = mm4_pkg::OUT_TDATA_W'({w_position, w_product});

endmodule

`default_nettype wire

// ===== tb/matrix_multiply_4x4_top_test.sv =====
// self-checking bench for matrix_multiply_4x4_top: streams A/B element pairs and
// checks every product entry against an in-bench Q4.12 x Q4.12 -> Q10.24 predictor
// depends on mm4_pkg and matrix_multiply_4x4_top
`timescale 1ns / 1ps

module matrix_multiply_4x4_top_test;

    localparam int DIM    = 4;
    localparam int ELEM_W = 16;
    localparam int CELLS  = DIM * DIM;
    localparam int IN_W   = ((2 * ELEM_W + 7) / 8) * 8;
    localparam int PROD_W = mm4_pkg::PROD_W;
    localparam int POS_W  = mm4_pkg::POS_W;
    localparam int OUT_W  = mm4_pkg::OUT_TDATA_W;
    localparam int RANDOM_ROUNDS = 31;
    localparam int CALM_ROUNDS   = 6;
    localparam int REPORT_LIMIT  = 10;

    // holds the element stores and the queue of product entries still owed by the block
    class matmul_checker;
        typedef struct {
            logic [PROD_W-1:0] value;
            logic [POS_W-1:0]  pos;
            logic              last;
        } t_entry;

        logic signed [ELEM_W-1:0] a_cells [CELLS];
        logic signed [ELEM_W-1:0] b_cells [CELLS];
        int     fill;
        t_entry owed_entries[$];
        int     errors;
        int     beats_in;
        int     entries_checked;
        int     pairs_done;

        function new();
            fill            = 0;
            errors          = 0;
            beats_in        = 0;
            entries_checked = 0;
            pairs_done      = 0;
        endfunction

        function int pending();
            return owed_entries.size();
        endfunction

        function void flag_error(string msg);
            errors++;
            if (errors <= REPORT_LIMIT) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endfunction

        // store one beat; the sixteenth beat closes the pair and yields all entries
        function void load_element(logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b);
            t_entry e;
            longint sum;
            beats_in++;
            a_cells[fill] = a;
            b_cells[fill] = b;
            fill++;
            if (fill == CELLS) begin
                fill = 0;
                pairs_done++;
                for (int i = 0; i < DIM; i++) begin
                    for (int j = 0; j < DIM; j++) begin
                        sum = 0;
                        for (int k = 0; k < DIM; k++) begin
                            sum += longint'(a_cells[i*DIM+k])
                                 * longint'(b_cells[k*DIM+j]);
                        end
                        e.value = sum[PROD_W-1:0];
                        e.pos   = POS_W'(i * DIM + j);
                        e.last  = (i == DIM - 1) && (j == DIM - 1);
                        owed_entries.push_back(e);
                    end
                end
            end
        endfunction

        function void check_entry(logic [OUT_W-1:0] data, logic last_flag);
            t_entry e;
            logic [PROD_W-1:0] got_value;
            logic [POS_W-1:0]  got_pos;
            got_value = data[PROD_W-1:0];
            got_pos   = data[PROD_W+POS_W-1:PROD_W];
            entries_checked++;
            if (owed_entries.size() == 0) begin
                flag_error($sformatf("unexpected entry value=%0d pos=%0d last=%0b",
                                     $signed(got_value), got_pos, last_flag));
                return;
            end
            e = owed_entries.pop_front();
            if (got_value !== e.value || got_pos !== e.pos || last_flag !== e.last) begin
                flag_error($sformatf({"exp value=%0d pos=%0d last=%0b, ",
                                      "got value=%0d pos=%0d last=%0b"},
                                     $signed(e.value), e.pos, e.last,
                                     $signed(got_value), got_pos, last_flag));
            end
        endfunction

        function void close_out();
            if (owed_entries.size() != 0) begin
                flag_error($sformatf("%0d product entries never arrived", owed_entries.size()));
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;   // a_element, b_element, zero pad
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;   // product_element, result_position, zero pad
    logic              m_axis_tlast;

    matmul_checker sb;
    int sender_gap_pct;
    int sink_stall_pct;
    int sink_hold;

    matrix_multiply_4x4_top #(
        .MATRIX_DIM  (DIM),
        .ELEMENT_BITS(ELEM_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #1000000;
        $display("matrix_multiply_4x4_top regression: fail");
        $finish;
    end

    // sink backpressure in bursts, with the burst length drawn at random
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct) begin
            sink_hold     <= $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_entry(m_axis_tdata, m_axis_tlast);
        end
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b);
        logic [IN_W-1:0] word;
        int gap;
        word = '0;
        word[ELEM_W-1:0]        = a;
        word[2*ELEM_W-1:ELEM_W] = b;
        if (sender_gap_pct > 0 && $urandom_range(0, 99) < sender_gap_pct) begin
            gap = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_W'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.load_element(a, b);
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [ELEM_W-1:0] pick_element(bit extremes_only);
        if (extremes_only) begin
            return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        end
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            4:       return 16'h1000;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [ELEM_W-1:0] dir_a [CELLS];
        logic [ELEM_W-1:0] dir_b [CELLS];
        bit extremes_only;

        sb             = new();
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        sink_hold      = 0;
        sink_stall_pct = 0;
        sender_gap_pct = 0;

        // A rows: all min, all max, small values, mixed; B columns: all min, all max,
        // identity-like, mixed -> most positive and most negative sums both show up
        dir_a = '{16'h8000, 16'h8000, 16'h8000, 16'h8000,
                  16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                  16'h0000, 16'h0001, 16'hffff, 16'h1000,
                  16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
        dir_b = '{16'h8000, 16'h7fff, 16'h1000, 16'h0001,
                  16'h8000, 16'h7fff, 16'h0000, 16'hffff,
                  16'h8000, 16'h7fff, 16'h0000, 16'h8000,
                  16'h8000, 16'h7fff, 16'h0000, 16'h7fff};

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int n = 0; n < CELLS; n++) begin
            send_beat(dir_a[n], dir_b[n]);
        end
        // hold the source until the whole product has drained
        wait_for_drain();

        for (int r = 0; r < RANDOM_ROUNDS; r++) begin
            if (r >= RANDOM_ROUNDS - CALM_ROUNDS) begin
                sender_gap_pct = 0;
                sink_stall_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0:       sender_gap_pct = 0;
                    1:       sender_gap_pct = 20;
                    default: sender_gap_pct = 50;
                endcase
                case ($urandom_range(0, 2))
                    0:       sink_stall_pct = 0;
                    1:       sink_stall_pct = 10;
                    default: sink_stall_pct = 35;
                endcase
            end
            extremes_only = ($urandom_range(0, 7) == 0);
            for (int n = 0; n < CELLS; n++) begin
                send_beat(pick_element(extremes_only), pick_element(extremes_only));
            end
            if (r % 8 == 3) begin
                wait_for_drain();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (4 * DIM + 20) @(posedge i_clk);
        sb.close_out();

        $display("multiplied %0d matrix pairs from %0d beats, checked %0d product entries",
                 sb.pairs_done, sb.beats_in, sb.entries_checked);
        $display({"stimulus: min/max/zero/unit elements, all-extreme pairs, ",
                  "random Q4.12, %0d errors"}, sb.errors);
        if (sb.errors == 0) begin
            $display("matrix_multiply_4x4_top regression: pass");
        end else begin
            $display("matrix_multiply_4x4_top regression: fail");
        end
        $finish;
    end

endmodule
